@@ design/tbc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants for the toy block cipher stream block.
// ----------------------------------------------------------------------------
package tbc_pkg;

  localparam int CHAR_W    = 8;
  localparam int KEY_W     = 40;
  localparam int SHIFT_W   = 5;
  localparam int BLK_BYTES = 16;
  localparam int IDX_W     = 4;
  localparam int LIM_W     = 5;
  localparam int SUM_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [SUM_W-1:0]  ALPHA_LEN = 7'd26;
  localparam logic [CHAR_W-1:0] ASCII_A   = 8'd65;
  localparam logic [CHAR_W-1:0] ASCII_Z   = 8'd90;
  localparam logic [CHAR_W-1:0] ASCII_LA  = 8'd97;
  localparam logic [CHAR_W-1:0] ASCII_LZ  = 8'd122;
  localparam logic [CHAR_W-1:0] PAD_CHAR  = 8'h41;
  localparam logic [CHAR_W-1:0] GF_POLY   = 8'h1B;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI = 1'b1;

  // MixColumns coefficient
  typedef enum logic [1:0] {
    COEF1,
    COEF2,
    COEF3
  } coef_t;

  // Control from sequencer to the shared multiply-accumulate unit
  typedef struct packed {
    logic  en;
    logic  first;
    logic  pad;
    coef_t coef;
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_ACC,
    ST_OUT
  } state_t;

  // Multiply by x in GF(2^8)
  function automatic logic [CHAR_W-1:0] xtime(input logic [CHAR_W-1:0] x);
    logic [CHAR_W-1:0] r;
    r = {x[CHAR_W-2:0], 1'b0};
    if (x[CHAR_W-1]) begin
      r = r ^ GF_POLY;
    end
    return r;
  endfunction

endpackage

@@ design/tbc_ram.sv @@
// ----------------------------------------------------------------------------
// tbc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/tbc_mac.sv @@
// ----------------------------------------------------------------------------
// tbc_mac
// Shared byte unit: parity mark, GF(2^8) scale by 1/2/3, XOR accumulate.
// ----------------------------------------------------------------------------
module tbc_mac (
  input  logic                          clk,
  input  tbc_pkg::mac_ctl_t             ctl,
  input  logic [tbc_pkg::CHAR_W-1:0]    rdata,
  output logic [tbc_pkg::CHAR_W-1:0]    acc
);
  import tbc_pkg::*;

  logic [CHAR_W-1:0] src_byte;
  logic [CHAR_W-1:0] par_byte;
  logic [CHAR_W-1:0] scaled;
  logic [CHAR_W-1:0] acc_r;
  logic [CHAR_W-1:0] acc_nxt;

  // Substitute padding, then set bit 7 on odd popcount
  always_comb begin
    src_byte = ctl.pad ? PAD_CHAR : rdata;
    par_byte = src_byte;
    par_byte[CHAR_W-1] = src_byte[CHAR_W-1] | (^src_byte);
  end

  // Scale by the MixColumns coefficient
  always_comb begin
    case (ctl.coef)
      COEF1:   scaled = par_byte;
      COEF2:   scaled = xtime(par_byte);
      COEF3:   scaled = xtime(par_byte) ^ par_byte;
      default: scaled = par_byte;
    endcase
  end

  // Load on the first term, fold in the rest
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.en) begin
      acc_nxt = ctl.first ? scaled : (acc_r ^ scaled);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

@@ design/toy_block_cipher_stream_top.sv @@
// ----------------------------------------------------------------------------
// toy_block_cipher_stream_top
// Vigenere letter shift into a 16-byte block buffer, then row rotation,
// parity marking and MixColumns, streamed out one byte per transaction.
// ----------------------------------------------------------------------------
// Non-letter: taken in ST_IDLE. Letter: taken, then one mod-26
//   compare-subtract step per cycle in ST_MOD while the sum is 26 or more,
//   then written. Block emission per output byte: 4 RAM reads, each read
//   then accumulated in the shared MAC, plus an output load that waits
//   while the sink stalls. No input is taken during emission.
// Reset (rst_n low, synchronous): buffer empty, keys zero, output idle.
module toy_block_cipher_stream_top (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [7:0] char_in
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tbc_pkg::CHAR_W-1:0]       in_tdata,
  input  logic                             in_tlast,   // end_of_message
  // out_tdata: [7:0] cipher_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tbc_pkg::CHAR_W-1:0]       out_tdata,
  output logic                             out_tlast,  // block_last
  output logic                             out_tuser,  // message_last
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tbc_pkg::KEY_W-1:0]        cfg_data
);
  import tbc_pkg::*;

  state_t             state_r,   state_nxt;
  logic [IDX_W-1:0]   fill_r,    fill_nxt;
  logic [SUM_W-1:0]   sum_r,     sum_nxt;
  logic               eom_r,     eom_nxt;
  logic [LIM_W-1:0]   limit_r,   limit_nxt;
  logic [IDX_W-1:0]   byte_r,    byte_nxt;
  logic [1:0]         term_r,    term_nxt;
  logic               mlast_r,   mlast_nxt;
  logic               ovld_r,    ovld_nxt;
  logic [CHAR_W-1:0]  odata_r,   odata_nxt;
  logic               oblast_r,  oblast_nxt;
  logic               omlast_r,  omlast_nxt;
  logic [KEY_W-1:0]   key_lo_r;
  logic [KEY_W-1:0]   key_hi_r;

  logic [2*KEY_W-1:0] key_all;
  logic [SHIFT_W-1:0] shift;
  logic [CHAR_W-1:0]  char_off;
  logic               is_letter;
  logic               in_acc;
  logic               out_load;
  logic [IDX_W-1:0]   raddr;
  logic [1:0]         coef_sel;
  logic               ram_we;
  logic [CHAR_W-1:0]  ram_wdata;
  logic [CHAR_W-1:0]  ram_rdata;
  logic [CHAR_W-1:0]  mac_acc;
  mac_ctl_t           mac_ctl;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0;
      key_hi_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEY_LO: key_lo_r <= cfg_data;
        CFG_KEY_HI: key_hi_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Key shift for the current buffer position
  assign key_all   = {key_hi_r, key_lo_r};
  assign shift     = key_all[SHIFT_W*fill_r +: SHIFT_W];
  assign char_off  = in_tdata - ASCII_A;
  assign is_letter = ((in_tdata >= ASCII_A) && (in_tdata <= ASCII_Z)) ||
                     ((in_tdata >= ASCII_LA) && (in_tdata <= ASCII_LZ));

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Read address: row term_r, column rotated by the row index
  assign raddr    = {term_r, byte_r[1:0] + term_r};
  assign coef_sel = term_r - byte_r[3:2];

  assign ram_wdata = CHAR_W'(sum_r) + ASCII_A;
  assign out_load  = (state_r == ST_OUT) && (!ovld_r || out_tready);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    eom_nxt    = eom_r;
    limit_nxt  = limit_r;
    byte_nxt   = byte_r;
    term_nxt   = term_r;
    mlast_nxt  = mlast_r;
    ram_we     = 1'b0;
    mac_ctl.en    = 1'b0;
    mac_ctl.first = (term_r == 2'd0);
    mac_ctl.pad   = ({1'b0, raddr} >= limit_r);
    case (coef_sel)
      2'd0:    mac_ctl.coef = COEF2;
      2'd1:    mac_ctl.coef = COEF3;
      default: mac_ctl.coef = COEF1;
    endcase

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_letter) begin
            sum_nxt   = SUM_W'(char_off[5:0]) + SUM_W'(shift);
            eom_nxt   = in_tlast;
            state_nxt = ST_MOD;
          end else if (in_tlast && (fill_r != '0)) begin
            limit_nxt = LIM_W'(fill_r);
            mlast_nxt = 1'b1;
            fill_nxt  = '0;
            byte_nxt  = '0;
            term_nxt  = '0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_MOD: begin
        if (sum_r >= ALPHA_LEN) begin
          sum_nxt = sum_r - ALPHA_LEN;
        end else begin
          ram_we   = 1'b1;
          byte_nxt = '0;
          term_nxt = '0;
          if (fill_r == IDX_W'(BLK_BYTES - 1)) begin
            fill_nxt  = '0;
            limit_nxt = LIM_W'(BLK_BYTES);
            mlast_nxt = eom_r;
            state_nxt = ST_RD;
          end else if (eom_r) begin
            fill_nxt  = '0;
            limit_nxt = LIM_W'(fill_r) + LIM_W'(1);
            mlast_nxt = 1'b1;
            state_nxt = ST_RD;
          end else begin
            fill_nxt  = fill_r + IDX_W'(1);
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        mac_ctl.en = 1'b1;
        term_nxt   = term_r + 2'd1;
        state_nxt  = (term_r == 2'd3) ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (out_load) begin
          if (byte_r == IDX_W'(BLK_BYTES - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            byte_nxt  = byte_r + IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: hold until taken
  always_comb begin
    ovld_nxt   = ovld_r;
    odata_nxt  = odata_r;
    oblast_nxt = oblast_r;
    omlast_nxt = omlast_r;
    if (out_tready) begin
      ovld_nxt = 1'b0;
    end
    if (out_load) begin
      ovld_nxt   = 1'b1;
      odata_nxt  = mac_acc;
      oblast_nxt = (byte_r == IDX_W'(BLK_BYTES - 1));
      omlast_nxt = mlast_r && (byte_r == IDX_W'(BLK_BYTES - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    eom_r    <= eom_nxt;
    limit_r  <= limit_nxt;
    byte_r   <= byte_nxt;
    term_r   <= term_nxt;
    mlast_r  <= mlast_nxt;
    odata_r  <= odata_nxt;
    oblast_r <= oblast_nxt;
    omlast_r <= omlast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = oblast_r;
  assign out_tuser  = omlast_r;

  // Block buffer
  tbc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (BLK_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r),
    .wdata (ram_wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Shared parity / MixColumns unit
  tbc_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .rdata (ram_rdata),
    .acc   (mac_acc)
  );

endmodule

@@ design/tbc_checker.sv @@
// ----------------------------------------------------------------------------
// tbc_checker
// Port-level checks for the toy block cipher stream block.
// ----------------------------------------------------------------------------
module tbc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [tbc_pkg::CHAR_W-1:0]    in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [tbc_pkg::CHAR_W-1:0]    out_tdata,
  input logic                          out_tlast,
  input logic                          out_tuser
);
  import tbc_pkg::*;

  logic in_letter;
  assign in_letter = ((in_tdata >= ASCII_A) && (in_tdata <= ASCII_Z)) ||
                     ((in_tdata >= ASCII_LA) && (in_tdata <= ASCII_LZ));

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // Message end only on a block end
  a_mlast_blast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("message_last without block_last");

  // A taken letter occupies the shifter and holds off further input
  a_letter_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_letter |=> !in_tready)
    else $error("input taken during letter shift");

  // No output in the first cycle after reset is released
  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind toy_block_cipher_stream_top tbc_checker u_tbc_checker (.*);

@@ sim/toy_block_cipher_stream_top_tb.sv @@
// ----------------------------------------------------------------------------
// toy_block_cipher_stream_top_tb
// Self-checking bench for the toy block cipher stream. A short table of
// directed characters runs first, then random messages under three key and
// back-pressure settings. Every accepted character goes through a local
// model of the letter shift, row rotation, parity marking and MixColumns.
// Every emitted byte is checked against the oldest expected byte.
// ----------------------------------------------------------------------------
module toy_block_cipher_stream_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbc_pkg::*;

  localparam int STALL_LIMIT       = 3000;  // cycles with no transaction at all
  localparam int PIPE_TAIL         = 20;    // letter still in flight after last byte
  localparam int END_TAIL          = 40;
  localparam int LETTERS_PER_PHASE = 28;
  localparam int DIR_N             = 25;

  // One expected output byte
  typedef struct packed {
    logic [CHAR_W-1:0] cbyte;
    logic              blk_end;
    logic              msg_end;
  } cipher_t;

  // One directed row; a typed row gives the value of every byte of its block
  typedef struct packed {
    logic              rekey;     // load all-ones shifts before this row
    logic [CHAR_W-1:0] ch;
    logic              eom;
    logic              typed;
    logic [CHAR_W-1:0] blk_byte;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // zero key after reset: lone 'A' padded with 'A' gives a flat block
    '{1'b0, 8'h41, 1'b1, 1'b1, 8'h41},
    '{1'b0, 8'h00, 1'b1, 1'b0, 8'h00},   // end of message on empty buffer
    '{1'b0, 8'h40, 1'b0, 1'b0, 8'h00},   // letter range borders, all dropped
    '{1'b0, 8'h5B, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h60, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h7B, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h7A, 1'b1, 1'b0, 8'h00},   // lowercase letter carrying the end
    // every shift at 31: full block, no end on its last letter
    '{1'b1, 8'h41, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h5A, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h61, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h7A, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h4D, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h6D, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h42, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h79, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h51, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h71, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h4E, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h6E, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h43, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h78, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h47, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h54, 1'b0, 1'b0, 8'h00},
    '{1'b0, 8'h80, 1'b1, 1'b0, 8'h00}    // end just after a completed block
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [CHAR_W-1:0]    in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [CHAR_W-1:0]    out_tdata;
  logic                 out_tlast;
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY_LO;
  logic [KEY_W-1:0]     cfg_data = '0;

  // Local copy of the block state
  logic [KEY_W-1:0]  key_lo_m = '0;
  logic [KEY_W-1:0]  key_hi_m = '0;
  logic [CHAR_W-1:0] letters_m [BLK_BYTES];
  int unsigned       fill_m = 0;

  cipher_t cipher_q [$];
  int      mismatches = 0;
  int      stall_cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  toy_block_cipher_stream_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [CHAR_W-1:0] gf_mul2(input logic [CHAR_W-1:0] x);
    return x[CHAR_W-1] ? ({x[CHAR_W-2:0], 1'b0} ^ GF_POLY) : {x[CHAR_W-2:0], 1'b0};
  endfunction

  function automatic logic [SHIFT_W-1:0] shift_at(input int unsigned pos);
    if (pos < 8) begin
      return key_lo_m[SHIFT_W*pos +: SHIFT_W];
    end
    return key_hi_m[SHIFT_W*(pos-8) +: SHIFT_W];
  endfunction

  // Rotate rows, mark odd parity, mix columns and queue the 16 bytes
  task automatic flush_block(input logic msg_end);
    logic [CHAR_W-1:0] rot [BLK_BYTES];
    logic [CHAR_W-1:0] a0, a1, a2, a3;
    logic [CHAR_W-1:0] mixed [BLK_BYTES];
    cipher_t           item;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        rot[4*r+j] = letters_m[4*r + ((j+r) % 4)];
      end
    end
    for (int i = 0; i < BLK_BYTES; i++) begin
      if (^rot[i]) begin
        rot[i][CHAR_W-1] = 1'b1;
      end
    end
    for (int j = 0; j < 4; j++) begin
      a0 = rot[j];
      a1 = rot[j+4];
      a2 = rot[j+8];
      a3 = rot[j+12];
      mixed[j]    = gf_mul2(a0) ^ gf_mul2(a1) ^ a1 ^ a2 ^ a3;
      mixed[j+4]  = a0 ^ gf_mul2(a1) ^ gf_mul2(a2) ^ a2 ^ a3;
      mixed[j+8]  = a0 ^ a1 ^ gf_mul2(a2) ^ gf_mul2(a3) ^ a3;
      mixed[j+12] = gf_mul2(a0) ^ a0 ^ a1 ^ a2 ^ gf_mul2(a3);
    end
    for (int k = 0; k < BLK_BYTES; k++) begin
      item = '{mixed[k], k == BLK_BYTES-1, msg_end && k == BLK_BYTES-1};
      cipher_q.insert(cipher_q.size(), item);
    end
    fill_m = 0;
  endtask

  // Shift and buffer one character, flushing a full or ended block
  task automatic encipher_char(input logic [CHAR_W-1:0] c, input logic eom);
    int  v;
    bit  is_letter;
    is_letter = (c >= ASCII_A && c <= ASCII_Z) || (c >= ASCII_LA && c <= ASCII_LZ);
    if (is_letter) begin
      v = (int'(c) - int'(ASCII_A) + int'(shift_at(fill_m))) % int'(ALPHA_LEN)
          + int'(ASCII_A);
      letters_m[fill_m] = CHAR_W'(v);
      fill_m++;
      if (fill_m == BLK_BYTES) begin
        flush_block(eom);
        return;
      end
    end
    if (eom && fill_m != 0) begin
      for (int i = fill_m; i < BLK_BYTES; i++) begin
        letters_m[i] = PAD_CHAR;
      end
      flush_block(1'b1);
    end
  endtask

  // Offer one character; called and left at a falling edge
  task automatic push_char(input logic [CHAR_W-1:0] c, input logic eom);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encipher_char(c, eom);
    @(negedge clk);
  endtask

  // Write both shift registers; block must be idle
  task automatic load_key(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_KEY_LO;
    cfg_data  <= lo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_lo_m = lo;
    @(negedge clk);
    cfg_index <= CFG_KEY_HI;
    cfg_data  <= hi;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    key_hi_m = hi;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every expected byte is out, then wait the tail
  task automatic drain(input int tail);
    in_tvalid <= 1'b0;
    do @(negedge clk); while (cipher_q.size() != 0);
    repeat (tail) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key(input int mode);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int p = 0; p < 8; p++) begin
      case (mode)
        0:       k[SHIFT_W*p +: SHIFT_W] = SHIFT_W'($urandom_range(0, 25));
        1:       k[SHIFT_W*p +: SHIFT_W] = SHIFT_W'($urandom_range(0, 31));
        default: begin
          case ($urandom_range(0, 3))
            0:       k[SHIFT_W*p +: SHIFT_W] = 5'd0;
            1:       k[SHIFT_W*p +: SHIFT_W] = 5'd25;
            2:       k[SHIFT_W*p +: SHIFT_W] = 5'd26;
            default: k[SHIFT_W*p +: SHIFT_W] = 5'd31;
          endcase
        end
      endcase
    end
    return k;
  endfunction

  function automatic logic [CHAR_W-1:0] rand_letter();
    if ($urandom_range(0, 1) == 0) begin
      return CHAR_W'($urandom_range(65, 90));
    end
    return CHAR_W'($urandom_range(97, 122));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_other();
    logic [CHAR_W-1:0] c;
    do begin
      c = CHAR_W'($urandom_range(0, 255));
    end while ((c >= ASCII_A && c <= ASCII_Z) || (c >= ASCII_LA && c <= ASCII_LZ));
    return c;
  endfunction

  // One message: letters with some noise, usually closed by an end mark
  task automatic send_message(output int n_letters);
    int len;
    int ending;
    n_letters = 0;
    case ($urandom_range(0, 3))
      0:       len = BLK_BYTES;
      1:       len = 2 * BLK_BYTES;
      default: len = $urandom_range(1, 40);
    endcase
    ending = $urandom_range(0, 9);   // 0-6 end on letter, 7-8 on trailer, 9 none
    for (int k = 0; k < len; k++) begin
      while ($urandom_range(0, 99) < 12) push_char(rand_other(), 1'b0);
      push_char(rand_letter(), (k == len - 1) && ending < 7);
      n_letters++;
    end
    if (ending == 7 || ending == 8) begin
      push_char(rand_other(), 1'b1);
    end
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check each output transaction against the oldest expectation
  always @(posedge clk) begin
    cipher_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        report_mismatch($sformatf("byte %02h with nothing expected", out_tdata));
      end else begin
        want = cipher_q.pop_front();
        if (out_tdata !== want.cbyte) begin
          report_mismatch($sformatf("cipher byte %02h, want %02h", out_tdata, want.cbyte));
        end
        if (out_tlast !== want.blk_end) begin
          report_mismatch($sformatf("block last %b, want %b", out_tlast, want.blk_end));
        end
        if (out_tuser !== want.msg_end) begin
          report_mismatch($sformatf("message last %b, want %b", out_tuser, want.msg_end));
        end
      end
    end
  end

  // Watchdog: restart on any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int got;
    int sent;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table, zero key first, then every shift at its maximum
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].rekey) begin
        drain(PIPE_TAIL);
        load_key('1, '1);
      end
      push_char(DIR_ROWS[i].ch, DIR_ROWS[i].eom);
      if (DIR_ROWS[i].typed) begin
        for (int k = 0; k < BLK_BYTES; k++) begin
          cipher_q[cipher_q.size() - BLK_BYTES + k].cbyte = DIR_ROWS[i].blk_byte;
        end
      end
    end
    drain(PIPE_TAIL);

    // Random messages: slow receiver, then slow sender, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 75 : 0;
      recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 23 : 0;
      load_key(rand_key(ph), rand_key(ph));
      sent = 0;
      while (sent < LETTERS_PER_PHASE) begin
        send_message(got);
        sent += got;
        if ($urandom_range(0, 7) == 0) begin
          drain(0);
        end
      end
      drain(PIPE_TAIL);
    end

    drain(END_TAIL);
    if (cipher_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never emitted", cipher_q.size()));
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ toy_block_cipher_stream_top.f @@
design/tbc_pkg.sv
design/tbc_ram.sv
design/tbc_mac.sv
design/toy_block_cipher_stream_top.sv
design/tbc_checker.sv
sim/toy_block_cipher_stream_top_tb.sv
